// ===== rtl/weighted_face_sampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// weighted_face_sampler_top_macros
// Assertion macros used by the weighted face sampler top.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_FACE_SAMPLER_TOP_MACROS_SVH
`define WEIGHTED_FACE_SAMPLER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the weighted face sampler.
// ----------------------------------------------------------------------------
package wfs_pkg;

    // default sizing of the weight table
    localparam int MAX_SIDES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed field widths
    localparam int RAND_W     = 16;
    localparam int BIT_W      = $clog2(RAND_W);
    localparam int FACE_W     = 5;
    localparam int IDX_IN_W   = 4;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // u / 65535 is compared as u * T <= prefix * (2^16 - 1)
    localparam int FRAC_SHIFT = 16;

    localparam logic [FACE_W-1:0] SIDE_COUNT_RST = 5'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_COUNT    = 2'd0,
        REG_WEIGHTED_MODE = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        CMD_ROLL = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

endpackage

// ===== rtl/wfs_table.sv =====
// ----------------------------------------------------------------------------
// wfs_table
// Weight memory with one write port, one registered read port and a
// per-entry valid bit so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wfs_table #(
    parameter int DEPTH = wfs_pkg::MAX_SIDES_DEF,
    parameter int WIDTH = wfs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    import wfs_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_ok_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    // valid bits cleared by reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[rd_addr];
        end
    end

    // entries never written read as zero
    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/wfs_alu.sv =====
// ----------------------------------------------------------------------------
// wfs_alu
// Shared adder / subtractor with carry out; on subtract the carry is set
// when a >= b.
// ----------------------------------------------------------------------------
module wfs_alu #(
    parameter int W = 37
) (
    input  wfs_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     sum,
    output logic             carry
);
    import wfs_pkg::*;

    logic [W-1:0] b_inv;
    logic [W:0]   full;

    // two's complement subtract by inverting b and adding one
    assign b_inv = (op == ALU_SUB) ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_inv} + (W + 1)'(op == ALU_SUB);

    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

// ===== rtl/weighted_face_sampler_top.sv =====
// ----------------------------------------------------------------------------
// weighted_face_sampler_top
// Picks a one-based face from a 16-bit random value, uniformly or by a
// loadable weight table.
// ----------------------------------------------------------------------------
// Takes one transaction at a time; in_ready is high only while the sequencer
// is idle. A load reads the old weight, takes it off the running total, then
// adds the new weight and writes it. A fair roll runs 16 restoring remainder
// steps of u mod n. A weighted roll sums the active total (skipped when n
// equals MAX_SIDES, where the kept running total is used), builds u * total
// by 16 shift-and-subtract steps, then, face by face up to the selected one,
// takes two steps to add weight * 65535 and test the sign. Every step goes
// through one shared adder. Results sit in an output register, so the next
// transaction can start while a face still waits to be taken. The weight
// table reads as all zero right after reset with no clearing pass.
`include "weighted_face_sampler_top_macros.svh"

module weighted_face_sampler_top #(
    parameter int MAX_SIDES   = wfs_pkg::MAX_SIDES_DEF,
    parameter int WEIGHT_BITS = wfs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [wfs_pkg::RAND_W-1:0]      random_value,
    input  logic [wfs_pkg::IDX_IN_W-1:0]    face_index,
    input  logic [wfs_pkg::WEIGHT_W-1:0]    weight,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wfs_pkg::FACE_W-1:0]      face
);
    import wfs_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDES);
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int PROD_W = RAND_W + SUM_W;
    localparam int ALU_W  = PROD_W + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LD_RD  = 10'b0000000010,
        S_LD_SUB = 10'b0000000100,
        S_LD_ADD = 10'b0000001000,
        S_MOD    = 10'b0000010000,
        S_TOTAL  = 10'b0000100000,
        S_MUL    = 10'b0001000000,
        S_SCAN_A = 10'b0010000000,
        S_SCAN_B = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic [FACE_W-1:0]   side_count_reg;
    logic                weighted_mode_reg;
    logic [SUM_W-1:0]    wtotal_reg, wtotal_next;
    logic [FACE_W-1:0]   cnt_reg, cnt_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;

    // datapath registers
    logic [RAND_W-1:0]      u_reg, u_next;
    logic [FACE_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]       ld_idx_reg, ld_idx_next;
    logic [WEIGHT_BITS-1:0] ld_w_reg, ld_w_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [ALU_W-1:0]       diff_reg, diff_next;
    logic [FACE_W-1:0]      rem_reg, rem_next;
    logic [FACE_W-1:0]      res_reg, res_next;
    logic [FACE_W-1:0]      face_reg, face_next;

    // shared unit and table signals
    alu_op_t                alu_op;
    logic [ALU_W-1:0]       alu_a, alu_b, alu_sum;
    logic                   alu_carry;
    logic                   tbl_we;
    logic [IDX_W-1:0]       tbl_rd_addr;
    logic [WEIGHT_BITS-1:0] entry;
    logic [ALU_W-1:0]       entry_ext;

    logic [FACE_W-1:0]      n_eff;
    logic [FACE_W-1:0]      cnt_inc;
    logic [FACE_W:0]        mod_cat;
    logic [FACE_W-1:0]      rem_step;

    wfs_table #(
        .DEPTH (MAX_SIDES),
        .WIDTH (WEIGHT_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (ld_idx_reg),
        .wr_data (ld_w_reg),
        .rd_addr (tbl_rd_addr),
        .rd_data (entry)
    );

    wfs_alu #(
        .W (ALU_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign face      = face_reg;

    assign entry_ext = ALU_W'(entry);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign mod_cat   = {rem_reg, u_reg[bit_reg]};
    assign rem_step  = alu_carry ? FACE_W'(alu_sum) : FACE_W'(mod_cat);

    // effective side count: zero acts as one, large values saturate
    always_comb
    begin
        if (side_count_reg == '0)
        begin
            n_eff = FACE_W'(1);
        end
        else if (32'(side_count_reg) > MAX_SIDES)
        begin
            n_eff = FACE_W'(MAX_SIDES);
        end
        else
        begin
            n_eff = side_count_reg;
        end
    end

    // sequencer and operand selection for the shared unit
    always_comb
    begin
        state_next     = state_reg;
        wtotal_next    = wtotal_reg;
        cnt_next       = cnt_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        u_next         = u_reg;
        n_next         = n_reg;
        ld_idx_next    = ld_idx_reg;
        ld_w_next      = ld_w_reg;
        total_next     = total_reg;
        diff_next      = diff_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        face_next      = face_reg;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        tbl_we         = 1'b0;
        tbl_rd_addr    = IDX_W'(cnt_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // first read of a table pass goes out while idle
                tbl_rd_addr = '0;
                if (in_valid)
                begin
                    u_next      = random_value;
                    n_next      = n_eff;
                    ld_idx_next = IDX_W'(face_index);
                    ld_w_next   = WEIGHT_BITS'(weight);
                    cnt_next    = '0;
                    bit_next    = BIT_W'(RAND_W - 1);
                    rem_next    = '0;
                    diff_next   = '0;
                    total_next  = '0;
                    if (command == CMD_LOAD)
                    begin
                        // out-of-range loads are dropped
                        if (32'(face_index) < MAX_SIDES)
                        begin
                            state_next = S_LD_RD;
                        end
                    end
                    else if (!weighted_mode_reg)
                    begin
                        state_next = S_MOD;
                    end
                    else if (32'(n_eff) == MAX_SIDES)
                    begin
                        // all faces active: kept total is the active total
                        total_next = wtotal_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_TOTAL;
                    end
                end
            end

            S_LD_RD:
            begin
                tbl_rd_addr = ld_idx_reg;
                state_next  = S_LD_SUB;
            end

            S_LD_SUB:
            begin
                // remove the old weight from the running total
                tbl_rd_addr = ld_idx_reg;
                alu_op      = ALU_SUB;
                alu_a       = ALU_W'(wtotal_reg);
                alu_b       = entry_ext;
                wtotal_next = SUM_W'(alu_sum);
                state_next  = S_LD_ADD;
            end

            S_LD_ADD:
            begin
                tbl_rd_addr = ld_idx_reg;
                alu_a       = ALU_W'(wtotal_reg);
                alu_b       = ALU_W'(ld_w_reg);
                wtotal_next = SUM_W'(alu_sum);
                tbl_we      = 1'b1;
                state_next  = S_IDLE;
            end

            S_MOD:
            begin
                // one restoring remainder step per cycle, msb first
                alu_op   = ALU_SUB;
                alu_a    = ALU_W'(mod_cat);
                alu_b    = ALU_W'(n_reg);
                rem_next = rem_step;
                if (bit_reg == '0)
                begin
                    res_next   = rem_step + 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            S_TOTAL:
            begin
                // sum of the active weights, read one ahead
                tbl_rd_addr = IDX_W'(cnt_inc);
                alu_a       = ALU_W'(total_reg);
                alu_b       = entry_ext;
                total_next  = SUM_W'(alu_sum);
                if (cnt_inc == n_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end

            S_MUL:
            begin
                // build -(u * total) by shift and subtract, msb first
                alu_op    = ALU_SUB;
                alu_a     = diff_reg << 1;
                alu_b     = u_reg[bit_reg] ? ALU_W'(total_reg) : '0;
                diff_next = alu_sum;
                if (bit_reg == '0)
                begin
                    state_next = S_SCAN_A;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            S_SCAN_A:
            begin
                // add weight * 2^16
                alu_a      = diff_reg;
                alu_b      = entry_ext << FRAC_SHIFT;
                diff_next  = alu_sum;
                state_next = S_SCAN_B;
            end

            S_SCAN_B:
            begin
                // subtract weight, then prefix * 65535 - u * total is in hand
                tbl_rd_addr = IDX_W'(cnt_inc);
                alu_op      = ALU_SUB;
                alu_a       = diff_reg;
                alu_b       = entry_ext;
                diff_next   = alu_sum;
                if (!alu_sum[ALU_W-1])
                begin
                    res_next   = cnt_inc;
                    state_next = S_EMIT;
                end
                else if (cnt_inc == n_reg)
                begin
                    res_next   = n_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = S_SCAN_A;
                end
            end

            S_EMIT:
            begin
                // hand the face over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    face_next      = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reset-cleared state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            side_count_reg    <= SIDE_COUNT_RST;
            weighted_mode_reg <= 1'b0;
            wtotal_reg        <= '0;
            cnt_reg           <= '0;
            bit_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wtotal_reg    <= wtotal_next;
            cnt_reg       <= cnt_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIDE_COUNT:    side_count_reg    <= cfg_data[FACE_W-1:0];
                    REG_WEIGHTED_MODE: weighted_mode_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        n_reg      <= n_next;
        ld_idx_reg <= ld_idx_next;
        ld_w_reg   <= ld_w_next;
        total_reg  <= total_next;
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        face_reg   <= face_next;
    end

    // checks
    `WFS_ASSERT_SAME(a_face_range, out_valid,
        (face != '0) && (32'(face) <= MAX_SIDES), "face out of range")
    `WFS_ASSERT_SAME(a_scan_bound, (state_reg == S_SCAN_B) || (state_reg == S_TOTAL),
        cnt_reg < n_reg, "table walk past active faces")
    `WFS_ASSERT_SAME(a_total_borrow, state_reg == S_LD_SUB,
        alu_carry, "running total smaller than the replaced weight")
    `WFS_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (command == CMD_LOAD),
        !$rose(out_valid), "load produced a result")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the weighted face sampler against its own face predictor. A short
// table of directed rows covers reset values, fair and weighted rolls, side
// count saturation, unmapped registers and an all-zero table. Random phases
// then vary the registers and mix loads with rolls. Both handshakes idle in
// random bursts. One long result stall backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import wfs_pkg::*;

    localparam int          MAX_SIDES     = MAX_SIDES_DEF;
    localparam int          RANDOM_ITEMS  = 550;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam int          TAIL_CYCLES   = 100;
    localparam int          PRESSURE_AT   = 120;
    localparam int          PRESSURE_LEN  = 400;
    localparam longint      TIMEOUT_NS    = 3_000_000;
    localparam longint unsigned FRAC_ONE  = 65535;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    typedef enum logic {
        ROW_REG  = 1'b0,
        ROW_ITEM = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        cmd_t                   cmd;
        logic [RAND_W-1:0]      rnd;
        logic [IDX_IN_W-1:0]    idx;
        logic [WEIGHT_W-1:0]    wt;
        logic                   known;
        logic [FACE_W-1:0]      known_face;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic [RAND_W-1:0]      random_value;
    logic [IDX_IN_W-1:0]    face_index;
    logic [WEIGHT_W-1:0]    weight;
    logic                   out_valid;
    logic                   out_ready;
    logic [FACE_W-1:0]      face;

    // shadow of the block state seen by the predictor
    logic [CFG_DATA_W-1:0]  side_shadow;
    logic                   mode_shadow;
    logic [WEIGHT_W-1:0]    weight_shadow [MAX_SIDES];

    logic [FACE_W-1:0]      faces_due [$];
    logic [FACE_W-1:0]      face_due;
    plan_row_t              plan [$];
    int                     mismatch_count;
    int                     faces_taken;
    bit                     quiet;

    weighted_face_sampler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .random_value (random_value),
        .face_index   (face_index),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .face         (face)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // effective side count: zero acts as one, large values saturate
    function automatic int unsigned active_sides(input logic [CFG_DATA_W-1:0] sides);
        if (sides == 0)
            return 1;
        if (sides > MAX_SIDES)
            return MAX_SIDES;
        return 32'(sides);
    endfunction

    // face for a roll under the current shadow state
    function automatic logic [FACE_W-1:0] predict_face(input logic [RAND_W-1:0] u);
        int unsigned     n;
        int unsigned     i;
        longint unsigned total;
        longint unsigned prefix;
        logic [FACE_W-1:0] pick;
        bit              found;
        n = active_sides(side_shadow);
        if (!mode_shadow)
            return FACE_W'((u % n) + 1);
        total = 0;
        for (i = 0; i < n; i++)
            total += weight_shadow[i];
        // first face whose prefix reaches the scaled random fraction
        prefix = 0;
        pick   = FACE_W'(n);
        found  = 1'b0;
        for (i = 0; i < n; i++)
        begin
            prefix += weight_shadow[i];
            if (!found && (longint'(u) * total <= prefix * FRAC_ONE))
            begin
                pick  = FACE_W'(i + 1);
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic plan_row_t load_row(input logic [RAND_W-1:0] rnd,
                                           input logic [IDX_IN_W-1:0] idx,
                                           input logic [WEIGHT_W-1:0] wt);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.cmd  = CMD_LOAD;
        row.rnd  = rnd;
        row.idx  = idx;
        row.wt   = wt;
        return row;
    endfunction

    function automatic plan_row_t roll_row(input logic [RAND_W-1:0] rnd, input logic known,
                                           input logic [FACE_W-1:0] known_face);
        plan_row_t row;
        row            = '0;
        row.kind       = ROW_ITEM;
        row.cmd        = CMD_ROLL;
        row.rnd        = rnd;
        row.known      = known;
        row.known_face = known_face;
        return row;
    endfunction

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input cmd_t cmd, input logic [RAND_W-1:0] rnd,
                             input logic [IDX_IN_W-1:0] idx, input logic [WEIGHT_W-1:0] wt,
                             input logic known, input logic [FACE_W-1:0] known_face);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= cmd;
        random_value <= rnd;
        face_index   <= idx;
        weight       <= wt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
            weight_shadow[idx] = wt;
        else if (known)
            faces_due.push_back(known_face);
        else
            faces_due.push_back(predict_face(rnd));
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (faces_due.size() != 0)
            @(posedge clk);
        // a trailing load may still be busy
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_SIDE_COUNT)
            side_shadow = data;
        else if (idx == REG_WEIGHTED_MODE)
            mode_shadow = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result sink: random stalls, one long hold-off
    initial
    begin : result_sink
        int  stall_left;
        int  run_left;
        bit  pressure_done;
        out_ready     = 1'b0;
        stall_left    = 0;
        run_left      = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ready <= 1'b1;
                run_left--;
            end
            else if (!pressure_done && faces_taken >= PRESSURE_AT)
            begin
                out_ready     <= 1'b0;
                stall_left    = PRESSURE_LEN - 1;
                pressure_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                run_left  = $urandom_range(1, 30) - 1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            faces_taken++;
            if (faces_due.size() == 0)
            begin
                $error("face: unexpected transaction, actual %0d", face);
                mismatch_count++;
            end
            else
            begin
                face_due = faces_due.pop_front();
                if (face !== face_due)
                begin
                    $error("face: expected %0d, actual %0d", face_due, face);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int                     items_sent;
        int                     count;
        int                     wait_cycles;
        int unsigned            n_active;
        logic [CFG_DATA_W-1:0]  sides;
        cmd_t                   cmd;
        logic [RAND_W-1:0]      rnd;
        logic [IDX_IN_W-1:0]    idx;
        logic [WEIGHT_W-1:0]    wt;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_ROLL;
        random_value   = '0;
        face_index     = '0;
        weight         = '0;
        mismatch_count = 0;
        faces_taken    = 0;
        quiet          = 1'b0;
        side_shadow    = SIDE_COUNT_RST;
        mode_shadow    = 1'b0;
        foreach (weight_shadow[i])
            weight_shadow[i] = '0;

        // fair rolls on reset values: six sides
        plan.push_back(roll_row(16'd0, 1'b1, 5'd1));
        plan.push_back(roll_row(16'd65535, 1'b1, 5'd4));
        plan.push_back(roll_row(16'd5, 1'b1, 5'd6));
        plan.push_back(roll_row(16'd6, 1'b1, 5'd1));
        // weighted with an all-zero table always gives face one
        plan.push_back(reg_row(REG_WEIGHTED_MODE, 5'd1));
        plan.push_back(roll_row(16'd65535, 1'b1, 5'd1));
        plan.push_back(roll_row(16'd0, 1'b1, 5'd1));
        // extreme weights, one of them on an inactive face
        plan.push_back(load_row(16'd65535, 4'd0, 16'hFFFF));
        plan.push_back(load_row(16'd0, 4'd15, 16'hFFFF));
        plan.push_back(load_row(16'd1234, 4'd3, 16'd1));
        plan.push_back(roll_row(16'd65535, 1'b0, '0));
        plan.push_back(roll_row(16'd0, 1'b1, 5'd1));
        plan.push_back(roll_row(16'd32768, 1'b0, '0));
        // zero side count acts as one face
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd0));
        plan.push_back(roll_row(16'd65535, 1'b1, 5'd1));
        // oversized side count saturates
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd31));
        plan.push_back(roll_row(16'd65535, 1'b0, '0));
        plan.push_back(roll_row(16'd40000, 1'b0, '0));
        // unmapped indexes change nothing
        plan.push_back(reg_row(REG_UNMAPPED_2, 5'd31));
        plan.push_back(reg_row(REG_UNMAPPED_3, 5'd0));
        plan.push_back(reg_row(REG_WEIGHTED_MODE, 5'd0));
        plan.push_back(roll_row(16'd65535, 1'b1, 5'd16));
        plan.push_back(roll_row(16'd17, 1'b1, 5'd2));
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd17));
        plan.push_back(roll_row(16'd31, 1'b1, 5'd16));
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd16));
        plan.push_back(roll_row(16'd65534, 1'b1, 5'd15));
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd1));
        plan.push_back(roll_row(16'd65535, 1'b1, 5'd1));
        // full table in weighted mode, first weight cleared
        plan.push_back(reg_row(REG_SIDE_COUNT, 5'd16));
        plan.push_back(reg_row(REG_WEIGHTED_MODE, 5'd1));
        plan.push_back(load_row(16'd0, 4'd0, 16'd0));
        plan.push_back(roll_row(16'd1, 1'b0, '0));
        plan.push_back(roll_row(16'd65535, 1'b0, '0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows
        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REG)
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            else
                send_item(plan[r].cmd, plan[r].rnd, plan[r].idx, plan[r].wt,
                          plan[r].known, plan[r].known_face);
        end

        // random phases, each under its own register setting
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       sides = 5'd0;
                1:       sides = CFG_DATA_W'($urandom_range(17, 31));
                2:       sides = 5'd16;
                default: sides = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            write_reg(REG_SIDE_COUNT, sides);
            write_reg(REG_WEIGHTED_MODE, ($urandom_range(0, 2) != 0) ? 5'd1 : 5'd0);
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNMAPPED_3 : REG_UNMAPPED_2,
                          CFG_DATA_W'($urandom));
            n_active = active_sides(sides);

            // the closing stretch runs without idling
            if (RANDOM_ITEMS - items_sent <= 60)
            begin
                quiet = 1'b1;
                count = RANDOM_ITEMS - items_sent;
            end
            else
            begin
                quiet = ($urandom_range(0, 4) == 0);
                count = $urandom_range(30, 70);
                if (count > RANDOM_ITEMS - items_sent - 30)
                    count = RANDOM_ITEMS - items_sent - 30;
            end

            repeat (count)
            begin
                cmd = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_ROLL;
                case ($urandom_range(0, 7))
                    0:       rnd = '0;
                    1:       rnd = '1;
                    default: rnd = RAND_W'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0)
                    idx = IDX_IN_W'($urandom_range(0, MAX_SIDES - 1));
                else
                    idx = IDX_IN_W'($urandom_range(0, n_active - 1));
                case ($urandom_range(0, 5))
                    0:       wt = '0;
                    1:       wt = '1;
                    2:       wt = WEIGHT_W'($urandom_range(1, 15));
                    default: wt = WEIGHT_W'($urandom);
                endcase
                send_item(cmd, rnd, idx, wt, 1'b0, '0);
                items_sent++;
            end
        end

        // drain and look for stray results
        @(negedge clk);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (faces_due.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (faces_due.size() != 0)
        begin
            $error("face: expected %0d, actual none", faces_due.pop_front());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wfs_pkg.sv
rtl/wfs_table.sv
rtl/wfs_alu.sv
rtl/weighted_face_sampler_top.sv
bench/testbench.sv
